// ===== src/fcf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the FIR convolution filter.
package fcf_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 18;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int ACC_W    = 48;
  localparam int FRAC_W   = 17;
  localparam int SEL_W    = 2;
  localparam int TAPS_W   = 7;
  localparam int CFG_IDX_W = 1;
  localparam int IN_DATA_W = 48;
  localparam int IN_USER_W = 3;

  localparam logic [TAPS_W-1:0] TAPS_RST = 7'd125;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_SELECT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_TAPS   = 1'd1;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_SAMPLE = 2'd1,
    ACT_FLUSH  = 2'd2
  } fcf_action_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_MAC   = 2'd1,
    ST_DRAIN = 2'd2
  } fcf_state_e;

  typedef struct packed {
    logic push;
    logic clr;
    logic shift;
  } fcf_cell_ctrl_t;

endpackage

// ===== src/fcf_cell.sv =====
`timescale 1ns / 1ps
// One tap cell: a history sample and a working copy that shifts toward the head.
module fcf_cell (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  fcf_pkg::fcf_cell_ctrl_t              ctrl_i,
  input  logic signed [fcf_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic signed [fcf_pkg::SAMPLE_W-1:0]  work_i,
  output logic signed [fcf_pkg::SAMPLE_W-1:0]  hist_o,
  output logic signed [fcf_pkg::SAMPLE_W-1:0]  work_o
);

  logic signed [fcf_pkg::SAMPLE_W-1:0] hist_q, hist_d;
  logic signed [fcf_pkg::SAMPLE_W-1:0] work_q;

  assign hist_d = ctrl_i.clr ? '0 : sample_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
      work_q <= '0;
    end else if (ctrl_i.push) begin
      hist_q <= hist_d;
      work_q <= hist_d;
    end else if (ctrl_i.shift) begin
      work_q <= work_i;
    end
  end

  assign hist_o = hist_q;
  assign work_o = work_q;

endmodule

// ===== src/fcf_mac.sv =====
`timescale 1ns / 1ps
// Multiply-accumulate unit with rounding and 16-bit saturation.
module fcf_mac (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic                                 vld_i,
  input  logic signed [fcf_pkg::SAMPLE_W-1:0]  samp_i,
  input  logic signed [fcf_pkg::COEF_W-1:0]    coef_i,
  output logic                                 busy_o,
  output logic signed [fcf_pkg::SAMPLE_W-1:0]  filtered_o,
  output logic                                 sat_o
);

  localparam int YW = fcf_pkg::ACC_W - fcf_pkg::FRAC_W;
  localparam logic signed [YW-1:0] YMax = YW'(32767);
  localparam logic signed [YW-1:0] YMin = YW'(-32768);
  localparam logic signed [fcf_pkg::ACC_W-1:0] RndHalf =
    fcf_pkg::ACC_W'(1 << (fcf_pkg::FRAC_W - 1));

  logic signed [fcf_pkg::PROD_W-1:0] prod_q;
  logic                              pvld_q;
  logic signed [fcf_pkg::ACC_W-1:0]  acc_q;
  logic signed [fcf_pkg::ACC_W-1:0]  rnd;
  logic signed [YW-1:0]              y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvld_q <= 1'b0;
    end else begin
      pvld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i) begin
      prod_q <= fcf_pkg::PROD_W'(samp_i) * fcf_pkg::PROD_W'(coef_i);
    end
    if (start_i) begin
      acc_q <= '0;
    end else if (pvld_q) begin
      acc_q <= acc_q + fcf_pkg::ACC_W'(prod_q);
    end
  end

  // floor((acc + 2^16) / 2^17), then clip
  always_comb begin
    rnd = acc_q + RndHalf;
    y   = $signed(rnd[fcf_pkg::ACC_W-1:fcf_pkg::FRAC_W]);
    if (y > YMax) begin
      filtered_o = fcf_pkg::SAMPLE_W'(YMax);
      sat_o      = 1'b1;
    end else if (y < YMin) begin
      filtered_o = fcf_pkg::SAMPLE_W'(YMin);
      sat_o      = 1'b1;
    end else begin
      filtered_o = y[fcf_pkg::SAMPLE_W-1:0];
      sat_o      = 1'b0;
    end
  end

  assign busy_o = pvld_q;

endmodule

// ===== src/fir_convolution_filter_top.sv =====
`timescale 1ns / 1ps
// Top level of the streaming FIR convolution filter.
//
//  channel  dir  handshake                  content
//  s_axis   in   s_axis_tvalid/tready       load, sample or flush request
//  m_axis   out  m_axis_tvalid/tready       filtered sample and clip flag
//  cfg      in   cfg_we_i                   filter_select, active_taps
//
//  A load request writes the coefficient memory and stays idle; a sample
//  or flush request does one coefficient-memory read and MAC per active tap.
//  The tap cells shift the working copy one tap per cycle into the MAC.
//  Reset clears the tap cells, control state and valid flags; data is not reset.
//  A stalled output holds the next result in the drain step until taken.
module fir_convolution_filter_top #(
  parameter int MAX_TAPS  = 125,
  parameter int NUM_BANKS = 3
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // bank[1:0], coef_index[8:2], coef_value[26:9], sample[42:27], zero pad
  input  logic [fcf_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // action[1:0], first_of_signal[2]
  input  logic [fcf_pkg::IN_USER_W-1:0]    s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // filtered[15:0]
  output logic [fcf_pkg::SAMPLE_W-1:0]     m_axis_tdata,
  // saturated
  output logic                             m_axis_tuser,
  input  logic                             cfg_we_i,
  input  logic [fcf_pkg::CFG_IDX_W-1:0]    cfg_addr_i,
  input  logic [fcf_pkg::TAPS_W-1:0]       cfg_wdata_i
);

  localparam int DEPTH = NUM_BANKS * MAX_TAPS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

  // request fields
  fcf_pkg::fcf_action_e                 action;
  logic [1:0]                           bank;
  logic [6:0]                           coef_index;
  logic signed [fcf_pkg::COEF_W-1:0]    coef_value;
  logic signed [fcf_pkg::SAMPLE_W-1:0]  sample;
  logic                                 first_of_signal;

  assign bank            = s_axis_tdata[1:0];
  assign coef_index      = s_axis_tdata[8:2];
  assign coef_value      = $signed(s_axis_tdata[26:9]);
  assign sample          = $signed(s_axis_tdata[42:27]);
  assign action          = fcf_pkg::fcf_action_e'(s_axis_tuser[1:0]);
  assign first_of_signal = s_axis_tuser[2];

  fcf_pkg::fcf_state_e state_q, state_d;
  logic [fcf_pkg::SEL_W-1:0]  fsel_q;
  logic [fcf_pkg::TAPS_W-1:0] taps_q;
  logic [IW-1:0]              idx_q;
  logic [AW-1:0]              base_q;
  logic                       rd_vld_q;
  logic signed [fcf_pkg::COEF_W-1:0]   coef_q;
  logic signed [fcf_pkg::SAMPLE_W-1:0] samp_q;
  logic                       out_valid_q;
  logic [fcf_pkg::SAMPLE_W-1:0] out_data_q;
  logic                       out_sat_q;

  logic signed [fcf_pkg::COEF_W-1:0] mem [DEPTH];

  logic                       accept;
  logic                       start;
  logic                       mem_we;
  logic                       rd_en;
  logic                       out_load;
  logic [fcf_pkg::SEL_W-1:0]  bank_sel;
  logic [IW-1:0]              t_m1;
  logic [AW-1:0]              wr_addr;
  logic [AW-1:0]              rd_addr;
  logic signed [fcf_pkg::SAMPLE_W-1:0] x_in;
  fcf_pkg::fcf_cell_ctrl_t    cell_ctrl;
  fcf_pkg::fcf_cell_ctrl_t    head_ctrl;

  logic                                mac_busy;
  logic signed [fcf_pkg::SAMPLE_W-1:0] mac_filtered;
  logic                                mac_sat;

  assign accept = s_axis_tvalid & s_axis_tready;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsel_q <= '0;
      taps_q <= fcf_pkg::TAPS_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        fcf_pkg::REG_FILTER_SELECT: fsel_q <= cfg_wdata_i[fcf_pkg::SEL_W-1:0];
        fcf_pkg::REG_ACTIVE_TAPS:   taps_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign bank_sel = (int'(fsel_q) >= NUM_BANKS) ? fcf_pkg::SEL_W'(NUM_BANKS - 1) : fsel_q;

  always_comb begin
    if (taps_q == '0) begin
      t_m1 = '0;
    end else if (int'(taps_q) > MAX_TAPS) begin
      t_m1 = IW'(MAX_TAPS - 1);
    end else begin
      t_m1 = IW'(taps_q - 7'd1);
    end
  end

  assign wr_addr = AW'(bank) * AW'(MAX_TAPS) + AW'(coef_index);
  assign rd_addr = base_q + AW'(idx_q);
  assign x_in    = (action == fcf_pkg::ACT_SAMPLE) ? sample : '0;

  // control
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    start         = 1'b0;
    mem_we        = 1'b0;
    rd_en         = 1'b0;
    out_load      = 1'b0;
    cell_ctrl     = '0;
    case (state_q)
      fcf_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          case (action)
            fcf_pkg::ACT_LOAD: begin
              mem_we = (int'(bank) < NUM_BANKS) && (int'(coef_index) < MAX_TAPS);
            end
            fcf_pkg::ACT_SAMPLE, fcf_pkg::ACT_FLUSH: begin
              start          = 1'b1;
              cell_ctrl.push = 1'b1;
              cell_ctrl.clr  = first_of_signal;
              state_d        = fcf_pkg::ST_MAC;
            end
            default: ;
          endcase
        end
      end
      fcf_pkg::ST_MAC: begin
        rd_en           = 1'b1;
        cell_ctrl.shift = 1'b1;
        if (idx_q == '0) begin
          state_d = fcf_pkg::ST_DRAIN;
        end
      end
      fcf_pkg::ST_DRAIN: begin
        if (!rd_vld_q && !mac_busy && (!out_valid_q || m_axis_tready)) begin
          out_load = 1'b1;
          state_d  = fcf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fcf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fcf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      base_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_en;
      if (start) begin
        idx_q  <= t_m1;
        base_q <= AW'(bank_sel) * AW'(MAX_TAPS);
      end else if (rd_en && idx_q != '0) begin
        idx_q <= idx_q - IW'(1);
      end
    end
  end

  // coefficient memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= coef_value;
    end
    if (rd_en) begin
      coef_q <= mem[rd_addr];
    end
  end

  // tap cell chain
  logic signed [fcf_pkg::SAMPLE_W-1:0] hist [MAX_TAPS];
  logic signed [fcf_pkg::SAMPLE_W-1:0] work [MAX_TAPS+1];

  assign work[MAX_TAPS] = '0;
  assign head_ctrl      = '{push: cell_ctrl.push, clr: 1'b0, shift: cell_ctrl.shift};

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    if (k == 0) begin : g_head
      fcf_cell u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ctrl_i   (head_ctrl),
        .sample_i (x_in),
        .work_i   (work[k+1]),
        .hist_o   (hist[k]),
        .work_o   (work[k])
      );
    end else begin : g_body
      fcf_cell u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ctrl_i   (cell_ctrl),
        .sample_i (hist[k-1]),
        .work_i   (work[k+1]),
        .hist_o   (hist[k]),
        .work_o   (work[k])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      samp_q <= work[0];
    end
  end

  fcf_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .vld_i      (rd_vld_q),
    .samp_i     (samp_q),
    .coef_i     (coef_q),
    .busy_o     (mac_busy),
    .filtered_o (mac_filtered),
    .sat_o      (mac_sat)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= mac_filtered;
      out_sat_q  <= mac_sat;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_sat_q;

  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fcf_pkg::ST_IDLE) |-> (!rd_vld_q && !mac_busy))
    else $error("MAC pipeline busy while idle");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fcf_pkg::ST_MAC) |-> (int'(idx_q) < MAX_TAPS))
    else $error("tap index out of range");

  a_sample_starts_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (action == fcf_pkg::ACT_SAMPLE || action == fcf_pkg::ACT_FLUSH))
      |=> (state_q == fcf_pkg::ST_MAC))
    else $error("sample request did not start the MAC");

  a_out_from_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == fcf_pkg::ST_DRAIN))
    else $error("result loaded outside the drain step");

endmodule
